// ===== sv/tcbf_pkg.sv =====
// package: shared types, constants and helpers for the hole table
package tcbf_pkg;
   localparam int TableEntries = 16;
   localparam int SizeWidth    = 31;
   localparam int LimitWidth   = 16;
   localparam logic [LimitWidth-1:0] SmallLimitReset = 16'd500;

   typedef enum logic [1:0] {
      ST_GRANTED   = 2'd0,
      ST_NO_FIT    = 2'd1,
      ST_STORED    = 2'd2,
      ST_DISCARDED = 2'd3
   } status_type;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef enum logic {
      REG_BATCH_CAP   = 1'b0,
      REG_SMALL_LIMIT = 1'b1
   } reg_index_type;

   typedef enum logic [2:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE,
      FSM_REINSERT,
      FSM_SHIFT,
      FSM_DONE
   } fsm_type;

   // per cell control, broadcast from the sequencer
   typedef struct packed {
      logic                 shift;     // take neighbor contents (compaction)
      logic                 write;     // write at selected index
      logic [SizeWidth-1:0] wr_size;
      logic [SizeWidth-1:0] wr_off;
   } cell_ctl_type;
endpackage

// ===== sv/tcbf_if.sv =====
// interfaces: valid/ready channels for request, response and csr
interface tcbf_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [30:0] size_words;
   logic [30:0] byte_offset;
   modport source (output valid, command, size_words, byte_offset, input ready);
   modport sink   (input valid, command, size_words, byte_offset, output ready);
endinterface

interface tcbf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [30:0] granted_size;
   logic [30:0] granted_offset;
   modport source (output valid, status, granted_size, granted_offset, input ready);
   modport sink   (input valid, status, granted_size, granted_offset, output ready);
endinterface

interface tcbf_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [30:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/tcbf_cell.sv =====
// cell: one table entry, shifts left from its right neighbor on compaction
`default_nettype none
module tcbf_cell (
   input  wire logic                          clock,
   input  wire tcbf_pkg::cell_ctl_type        ctl,
   input  wire logic                          sel,        // write targets this cell
   input  wire logic                          shift_en,   // cell at or past removal point
   input  wire logic [tcbf_pkg::SizeWidth-1:0] nb_size,
   input  wire logic [tcbf_pkg::SizeWidth-1:0] nb_off,
   output logic      [tcbf_pkg::SizeWidth-1:0] size_q,
   output logic      [tcbf_pkg::SizeWidth-1:0] off_q
);
   logic [tcbf_pkg::SizeWidth-1:0] size_ff, size_in, off_ff, off_in;

   // entry update
   always_comb begin
      size_in = size_ff;
      off_in  = off_ff;
      if (ctl.write && sel) begin
         size_in = ctl.wr_size;
         off_in  = ctl.wr_off;
      end else if (ctl.shift && shift_en) begin
         size_in = nb_size;
         off_in  = nb_off;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in;
      off_ff  <= off_in;
   end

   assign size_q = size_ff;
   assign off_q  = off_ff;
endmodule
`default_nettype wire

// ===== sv/tcbf_table.sv =====
// table: a chain of cells plus a read port at the scan / write / remove index
`default_nettype none
module tcbf_table #(
   parameter int TABLE_ENTRIES = tcbf_pkg::TableEntries
) (
   input  wire logic                          clock,
   input  wire tcbf_pkg::cell_ctl_type        ctl,
   input  wire logic [$clog2(TABLE_ENTRIES)-1:0] idx,   // scan / write / remove index
   output logic      [tcbf_pkg::SizeWidth-1:0] rd_size,
   output logic      [tcbf_pkg::SizeWidth-1:0] rd_off
);
   localparam int IW = $clog2(TABLE_ENTRIES);
   logic [tcbf_pkg::SizeWidth-1:0] sz [TABLE_ENTRIES];
   logic [tcbf_pkg::SizeWidth-1:0] of [TABLE_ENTRIES];

   // chain of cells; each takes its right neighbor on a shift
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      logic [tcbf_pkg::SizeWidth-1:0] nbs, nbo;
      if (g == TABLE_ENTRIES - 1) begin : g_end
         assign nbs = sz[g];
         assign nbo = of[g];
      end else begin : g_mid
         assign nbs = sz[g+1];
         assign nbo = of[g+1];
      end
      tcbf_cell u_cell (
         .clock    (clock),
         .ctl      (ctl),
         .sel      (idx == IW'(g)),
         .shift_en (IW'(g) >= idx),
         .nb_size  (nbs),
         .nb_off   (nbo),
         .size_q   (sz[g]),
         .off_q    (of[g])
      );
   end

   // read port for the scan and the chosen entry
   assign rd_size = sz[idx];
   assign rd_off  = of[idx];
endmodule
`default_nettype wire

// ===== sv/two_class_best_fit_hole_table.sv =====
// top level: two hole tables of cells and the allocate/free sequencer
//
//   channel | dir | payload
//   req_    | in  | command, size_words, byte_offset
//   rsp_    | out | status, granted_size, granted_offset
//   csr_    | in  | index (0 batch_cap, 1 small_limit), data
//
// one word at a time: a new word is taken only in idle, after the last response is taken.
// the scan of the chosen table checks one entry per cycle. a free appends when the table
// has room, else scans it for the minimum; an allocate scans it for the best fit,
// the compaction shift moving the whole chain at once.
// a split large hole re-offered to the small table adds a reinsert scan of that table.
// reset clears the counts and batch_cap and sets small_limit to 500; a stalled response holds the sequencer.
`default_nettype none
module two_class_best_fit_hole_table #(
   parameter int TABLE_ENTRIES = tcbf_pkg::TableEntries
) (
   input  wire logic clock,
   input  wire logic reset,
   tcbf_req_if.sink   req,
   tcbf_rsp_if.source rsp,
   tcbf_csr_if.sink   csr
);
   localparam int IW = $clog2(TABLE_ENTRIES);
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam int SW = tcbf_pkg::SizeWidth;

   tcbf_pkg::fsm_type state_ff, state_in;
   logic [SW-1:0] cap_ff;
   logic [tcbf_pkg::LimitWidth-1:0] lim_ff;
   logic [CW-1:0] cnt_ff [2];
   logic [CW-1:0] cnt_in [2];
   logic [IW-1:0] idx_ff, idx_in, best_ff, best_in;
   logic found_ff, found_in, tsel_ff, tsel_in, ins_ff, ins_in;
   logic [SW-1:0] size_ff, size_in, off_ff, off_in;
   logic [SW-1:0] bsize_ff, bsize_in;
   logic [1:0] st_ff, st_in;
   logic [SW-1:0] gs_ff, gs_in, go_ff, go_in;
   logic rv_ff, rv_in;
   tcbf_pkg::cell_ctl_type ctl [2];
   logic [IW-1:0] tidx [2];
   logic [SW-1:0] rsz [2], rof [2];
   logic [SW+3:0] prod;
   logic [SW+3:0] hs10;
   logic [SW-1:0] rest;
   logic [SW-1:0] cur;
   logic [IW-1:0] scan_end;

   // two tables of cells
   for (genvar t = 0; t < 2; t++) begin : g_tab
      tcbf_table #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_tab (
         .clock(clock), .ctl(ctl[t]), .idx(tidx[t]), .rd_size(rsz[t]), .rd_off(rof[t]));
   end

   // configuration registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= '0;
         lim_ff <= tcbf_pkg::SmallLimitReset;
      end else if (csr.valid) begin
         unique case (tcbf_pkg::reg_index_type'(csr.index))
            tcbf_pkg::REG_BATCH_CAP:   cap_ff <= csr.data;
            tcbf_pkg::REG_SMALL_LIMIT: lim_ff <= csr.data[tcbf_pkg::LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   // slack test without a divide: 10*hole <= 12*req (large) or 11*req (small)
   assign prod   = tsel_ff ? ({4'd0, size_ff} * (SW+4)'(12)) : ({4'd0, size_ff} * (SW+4)'(11));
   assign hs10   = {4'd0, bsize_ff} * (SW+4)'(10);
   assign rest   = bsize_ff - size_ff;
   assign cur    = rsz[tsel_ff];
   assign scan_end = IW'(TABLE_ENTRIES - 1);

   // sequencer
   always_comb begin
      logic full;
      state_in = state_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      best_in  = best_ff;
      found_in = found_ff;
      tsel_in  = tsel_ff;
      ins_in   = ins_ff;
      size_in  = size_ff;
      off_in   = off_ff;
      bsize_in = bsize_ff;
      st_in    = st_ff;
      gs_in    = gs_ff;
      go_in    = go_ff;
      rv_in    = rv_ff;
      full     = cnt_ff[tsel_ff] == CW'(TABLE_ENTRIES);
      for (int t = 0; t < 2; t++) begin
         ctl[t]  = '0;
         tidx[t] = idx_ff;
      end
      ctl[tsel_ff].wr_size = size_ff;
      ctl[tsel_ff].wr_off  = off_ff;
      unique case (state_ff)
         tcbf_pkg::FSM_IDLE: begin
            if (req.valid) begin
               size_in  = req.size_words;
               off_in   = req.byte_offset;
               tsel_in  = req.size_words > {15'd0, lim_ff};
               ins_in   = req.command == tcbf_pkg::CMD_FREE;
               idx_in   = '0;
               best_in  = '0;
               found_in = 1'b0;
               gs_in    = '0;
               go_in    = '0;
               state_in = tcbf_pkg::FSM_SCAN;
               if (req.command == tcbf_pkg::CMD_FREE)
                  st_in = tcbf_pkg::ST_STORED;
            end
         end
         // serial scan: best fit for allocate, minimum for free when full; a free with room appends
         tcbf_pkg::FSM_SCAN: begin
            if (ins_ff && !full) begin
               ctl[tsel_ff].write = 1'b1;
               tidx[tsel_ff] = cnt_ff[tsel_ff][IW-1:0];
               cnt_in[tsel_ff] = cnt_ff[tsel_ff] + CW'(1);
               state_in = tcbf_pkg::FSM_DONE;
            end else if (!ins_ff && CW'(idx_ff) >= cnt_ff[tsel_ff]) begin
               state_in = tcbf_pkg::FSM_DECIDE;
            end else begin
               if (ins_ff) begin
                  if (!found_ff || cur < bsize_ff) begin
                     best_in = idx_ff; bsize_in = cur; found_in = 1'b1;
                  end
               end else if (cur >= size_ff && (!found_ff || cur < bsize_ff)) begin
                  best_in = idx_ff; bsize_in = cur; found_in = 1'b1;
               end
               idx_in = idx_ff + IW'(1);
               if (idx_ff == scan_end) state_in = tcbf_pkg::FSM_DECIDE;
            end
         end
         tcbf_pkg::FSM_DECIDE: begin
            tidx[tsel_ff] = best_ff;
            if (ins_ff) begin
               if (size_ff > bsize_ff) begin
                  ctl[tsel_ff].write = 1'b1;
               end else st_in = tcbf_pkg::ST_DISCARDED;
               state_in = tcbf_pkg::FSM_DONE;
            end else if (!found_ff) begin
               st_in = tcbf_pkg::ST_NO_FIT;
               state_in = tcbf_pkg::FSM_DONE;
            end else begin
               st_in = tcbf_pkg::ST_GRANTED;
               go_in = rof[tsel_ff];
               if (bsize_ff == size_ff || (bsize_ff <= cap_ff && hs10 <= prod)) begin
                  gs_in = bsize_ff;
                  ins_in = 1'b0;
                  state_in = tcbf_pkg::FSM_SHIFT;
               end else begin
                  gs_in = size_ff;
                  off_in = rof[tsel_ff] + {size_ff[SW-3:0], 2'b00};
                  ctl[tsel_ff].write = 1'b1;
                  ctl[tsel_ff].wr_size = rest;
                  ctl[tsel_ff].wr_off = rof[tsel_ff] + {size_ff[SW-3:0], 2'b00};
                  size_in = rest;
                  if (tsel_ff && rest <= {15'd0, lim_ff}) begin
                     ins_in = 1'b1;
                     state_in = tcbf_pkg::FSM_SHIFT;
                  end else state_in = tcbf_pkg::FSM_DONE;
               end
            end
         end
         // compaction: chain shifts left from the chosen entry as the count drops
         tcbf_pkg::FSM_SHIFT: begin
            tidx[tsel_ff] = best_ff;
            ctl[tsel_ff].shift = 1'b1;
            cnt_in[tsel_ff] = cnt_ff[tsel_ff] - CW'(1);
            if (ins_ff) begin
               tsel_in = 1'b0; idx_in = '0; found_in = 1'b0;
               state_in = tcbf_pkg::FSM_REINSERT;
            end else state_in = tcbf_pkg::FSM_DONE;
         end
         tcbf_pkg::FSM_REINSERT: state_in = tcbf_pkg::FSM_SCAN;
         tcbf_pkg::FSM_DONE: begin
            if (!rv_ff) rv_in = 1'b1;
            else if (rsp.ready) begin
               rv_in = 1'b0; state_in = tcbf_pkg::FSM_IDLE;
            end
         end
         default: state_in = tcbf_pkg::FSM_IDLE;
      endcase
   end

   // in the reinsert scan, the status stays granted
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcbf_pkg::FSM_IDLE;
         cnt_ff[0] <= '0;
         cnt_ff[1] <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rv_ff <= rv_in;
      end
      idx_ff <= idx_in; best_ff <= best_in;
      found_ff <= found_in; tsel_ff <= tsel_in; ins_ff <= ins_in;
      size_ff <= size_in; off_ff <= off_in; bsize_ff <= bsize_in;
      st_ff <= (state_ff == tcbf_pkg::FSM_DECIDE && ins_ff && gs_ff != '0) ? st_ff : st_in;
      gs_ff <= gs_in; go_ff <= go_in;
   end

   assign req.ready = state_ff == tcbf_pkg::FSM_IDLE;
   assign rsp.valid = rv_ff;
   assign rsp.status = (gs_ff != '0 || go_ff != '0) ? 2'(tcbf_pkg::ST_GRANTED) : st_ff;
   assign rsp.granted_size = gs_ff;
   assign rsp.granted_offset = go_ff;
endmodule
`default_nettype wire

// ===== sv/tcbf_checker.sv =====
// checker: port-level properties of the hole table, bound to the top level
`default_nettype none
module tcbf_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic [30:0] rsp_granted_size
);
   // no new word while a response is pending
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken during response");
   // response held under stall
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped");
   // non-grant results carry zero size
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != tcbf_pkg::ST_GRANTED |-> rsp_granted_size == '0)
      else $error("size on non-grant");
endmodule

bind two_class_best_fit_hole_table tcbf_checker u_tcbf_checker (
   .clock(clock), .reset(reset),
   .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_status(rsp.status), .rsp_granted_size(rsp.granted_size));
`default_nettype wire

// ===== verif/tb_two_class_best_fit_hole_table.sv =====
// testbench for the two-class best-fit hole table: predictor, stimulus and checker
`default_nettype none
module tb_two_class_best_fit_hole_table;
   localparam int N = tcbf_pkg::TableEntries;
   localparam int CycleLimit = 2000000;

   typedef struct packed {
      logic [1:0]  status;
      logic [30:0] gsize;
      logic [30:0] goff;
   } grant_word_type;

   logic clock;
   logic reset;
   int   cycle_count = 0;
   int   fail_count = 0;

   tcbf_req_if req();
   tcbf_rsp_if rsp();
   tcbf_csr_if csr();

   two_class_best_fit_hole_table DUT (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   // predictor state
   logic [30:0] sm_size [N];
   logic [30:0] sm_off  [N];
   logic [30:0] lg_size [N];
   logic [30:0] lg_off  [N];
   int          sm_cnt;
   int          lg_cnt;
   logic [30:0] cap_reg;
   logic [15:0] limit_reg;

   grant_word_type grant_queue[$];

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // compaction of one table
   task automatic tbl_remove(bit is_large, int idx);
      int cnt;
      cnt = is_large ? lg_cnt : sm_cnt;
      for (int i = idx; i + 1 < cnt; i++) begin
         if (is_large) begin
            lg_size[i] = lg_size[i+1];
            lg_off[i] = lg_off[i+1];
         end else begin
            sm_size[i] = sm_size[i+1];
            sm_off[i] = sm_off[i+1];
         end
      end
      if (is_large) lg_cnt--; else sm_cnt--;
   endtask

   // store a hole: append, or replace the smallest entry when full and the hole is larger
   function automatic bit tbl_store(logic [30:0] sz, logic [30:0] off);
      bit is_large;
      int m;
      is_large = {16'd0, sz} > {15'd0, limit_reg};
      if (!is_large && sm_cnt < N) begin
         sm_size[sm_cnt] = sz; sm_off[sm_cnt] = off; sm_cnt++; return 1;
      end
      if (is_large && lg_cnt < N) begin
         lg_size[lg_cnt] = sz; lg_off[lg_cnt] = off; lg_cnt++; return 1;
      end
      m = 0;
      for (int i = 1; i < N; i++)
         if ((is_large ? lg_size[i] : sm_size[i]) < (is_large ? lg_size[m] : sm_size[m])) m = i;
      if (sz > (is_large ? lg_size[m] : sm_size[m])) begin
         if (is_large) begin lg_size[m] = sz; lg_off[m] = off; end
         else begin sm_size[m] = sz; sm_off[m] = off; end
         return 1;
      end
      return 0;
   endfunction

   // best-fit allocation
   task automatic predict_alloc(logic [30:0] rq, output grant_word_type w);
      bit is_large, found;
      int best, cnt;
      logic [30:0] hs, ho, rest, noff;
      logic [63:0] scaled, bound;
      bit dummy;
      is_large = {16'd0, rq} > {15'd0, limit_reg};
      cnt = is_large ? lg_cnt : sm_cnt;
      found = 0; best = 0;
      w = '0;
      for (int i = 0; i < cnt; i++) begin
         hs = is_large ? lg_size[i] : sm_size[i];
         if (hs >= rq && (!found || hs < (is_large ? lg_size[best] : sm_size[best]))) begin
            best = i; found = 1;
         end
      end
      if (!found) begin
         w.status = tcbf_pkg::ST_NO_FIT;
         return;
      end
      hs = is_large ? lg_size[best] : sm_size[best];
      ho = is_large ? lg_off[best] : sm_off[best];
      scaled = is_large ? (64'(rq) * 6) / 5 : (64'(rq) * 11) / 10;
      bound = (scaled < 64'(cap_reg)) ? scaled : 64'(cap_reg);
      w.status = tcbf_pkg::ST_GRANTED;
      w.goff = ho;
      if (hs == rq || 64'(hs) <= bound) begin
         w.gsize = hs;
         tbl_remove(is_large, best);
      end else begin
         rest = hs - rq;
         noff = 31'(64'(ho) + 64'(rq) * 4);
         w.gsize = rq;
         if (is_large) begin lg_size[best] = rest; lg_off[best] = noff; end
         else begin sm_size[best] = rest; sm_off[best] = noff; end
         if (is_large && {16'd0, rest} <= {15'd0, limit_reg}) begin
            tbl_remove(1, best);
            dummy = tbl_store(rest, noff);
         end
      end
   endtask

   // random gap, mostly short
   task automatic gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
          ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
      repeat (n) @(posedge clock);
   endtask

   // send one word and queue its expected result
   task automatic send_word(tcbf_pkg::command_type cmd, logic [30:0] sz, logic [30:0] off);
      grant_word_type w;
      if ($urandom_range(0, 3) == 0) gap();
      req.valid <= 1'b1;
      req.command <= cmd;
      req.size_words <= sz;
      req.byte_offset <= off;
      do @(posedge clock); while (!req.ready);
      req.valid <= 1'b0;
      if (cmd == tcbf_pkg::CMD_ALLOC) predict_alloc(sz, w);
      else begin
         w = '0;
         w.status = tbl_store(sz, off) ? tcbf_pkg::ST_STORED : tcbf_pkg::ST_DISCARDED;
      end
      grant_queue.push_back(w);
      // the block is busy after taking a word
      @(posedge clock);
   endtask

   task automatic drain();
      while (grant_queue.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic write_reg(tcbf_pkg::reg_index_type idx, logic [30:0] val);
      drain();
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == tcbf_pkg::REG_BATCH_CAP) cap_reg = val;
      else limit_reg = val[15:0];
   endtask

   // response checker with random stalls
   initial begin
      grant_word_type e;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            if (grant_queue.size() == 0) begin
               $error("unexpected word status=%0d", rsp.status);
               fail_count++;
            end else begin
               e = grant_queue.pop_front();
               if (rsp.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp.status);
                  fail_count++;
               end
               if (rsp.granted_size !== e.gsize) begin
                  $error("granted_size expected %0d actual %0d", e.gsize, rsp.granted_size);
                  fail_count++;
               end
               if (rsp.granted_offset !== e.goff) begin
                  $error("granted_offset expected %0d actual %0d", e.goff,
                         rsp.granted_offset);
                  fail_count++;
               end
            end
         end
         if ($urandom_range(0, 9) == 0) rsp.ready <= 1'b0;
         else if ($urandom_range(0, 29) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
            rsp.ready <= 1'b1;
         end else rsp.ready <= 1'b1;
      end
   end

   // directed: field extremes, both commands, zero size, wrap, full tables
   task automatic test_directed();
      send_word(tcbf_pkg::CMD_ALLOC, 31'd5, 31'd0);
      send_word(tcbf_pkg::CMD_FREE, 31'd0, 31'h7FFFFFFF);
      send_word(tcbf_pkg::CMD_ALLOC, 31'd0, 31'h7FFFFFFF);
      send_word(tcbf_pkg::CMD_FREE, 31'h7FFFFFFF, 31'h7FFFFFF0);
      send_word(tcbf_pkg::CMD_ALLOC, 31'd1000, 31'd0);
      send_word(tcbf_pkg::CMD_ALLOC, 31'h7FFFFFFF, 31'd0);
      send_word(tcbf_pkg::CMD_FREE, 31'd520, 31'd64);
      send_word(tcbf_pkg::CMD_ALLOC, 31'd510, 31'd0);
      send_word(tcbf_pkg::CMD_FREE, 31'd100, 31'd4000);
      send_word(tcbf_pkg::CMD_ALLOC, 31'd100, 31'd0);
      for (int i = 0; i < 18; i++)
         send_word(tcbf_pkg::CMD_FREE, 31'(i * 7 + 3), 31'(i * 256));
      drain();
   endtask

   // slack bound with batch cap
   task automatic test_slack();
      write_reg(tcbf_pkg::REG_BATCH_CAP, 31'h7FFFFFFF);
      send_word(tcbf_pkg::CMD_FREE, 31'd110, 31'd8);
      send_word(tcbf_pkg::CMD_ALLOC, 31'd100, 31'd0);
      send_word(tcbf_pkg::CMD_FREE, 31'd1200, 31'd80);
      send_word(tcbf_pkg::CMD_ALLOC, 31'd1000, 31'd0);
      send_word(tcbf_pkg::CMD_ALLOC, 31'd200, 31'd0);
      drain();
   endtask

   // random words; pause sender at the midpoint until all results are in, then resume
   task automatic test_random(int items, int maxsize);
      bit fr;
      logic [30:0] sz;
      for (int k = 0; k < items; k++) begin
         fr = $urandom_range(0, 1);
         case ($urandom_range(0, 9))
            0: sz = 31'($urandom());
            1: sz = 31'h7FFFFFFF;
            2: sz = 31'(limit_reg) + 31'($urandom_range(0, 2)) - 31'd1;
            default: sz = 31'($urandom_range(0, maxsize));
         endcase
         send_word(fr ? tcbf_pkg::CMD_FREE : tcbf_pkg::CMD_ALLOC, sz, 31'($urandom()));
         if (k == items / 2) drain();
      end
      drain();
   endtask

   initial begin
      sm_cnt = 0; lg_cnt = 0;
      cap_reg = '0; limit_reg = tcbf_pkg::SmallLimitReset;
      reset <= 1'b1;
      req.valid <= 1'b0; req.command <= tcbf_pkg::CMD_ALLOC;
      req.size_words <= '0; req.byte_offset <= '0;
      csr.valid <= 1'b0; csr.index <= tcbf_pkg::REG_BATCH_CAP; csr.data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_slack();
      test_random(300, 1500);
      write_reg(tcbf_pkg::REG_SMALL_LIMIT, 31'd1);
      write_reg(tcbf_pkg::REG_BATCH_CAP, 31'd0);
      test_random(200, 40);
      write_reg(tcbf_pkg::REG_SMALL_LIMIT, 31'd65535);
      write_reg(tcbf_pkg::REG_BATCH_CAP, 31'd300);
      test_random(300, 80000);
      write_reg(tcbf_pkg::REG_SMALL_LIMIT, 31'd500);
      write_reg(tcbf_pkg::REG_BATCH_CAP, 31'd5000);
      test_random(300, 2000);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end
endmodule
